// ===== hw/rtl/fibonacci_fast_doubling_defines.svh =====
// Assertion macros shared by the fast-doubling Fibonacci RTL.
// Each macro expects clk and rst to exist in the including module.
`ifndef FIBONACCI_FAST_DOUBLING_DEFINES_SVH
`define FIBONACCI_FAST_DOUBLING_DEFINES_SVH

// Same-cycle implication.
`define FIBFD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fibfd assertion failed");

// Consequent checked a fixed number of cycles later.
`define FIBFD_ASSERT_DLY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error("fibfd delayed assertion failed");

`endif

// ===== hw/rtl/fibfd_pkg.sv =====
// Package for the fast-doubling Fibonacci pipeline.
// Holds widths, stage counts and the token type passed between doubling steps.
package fibfd_pkg;

  localparam int IDX_BITS    = 16;
  localparam int VAL_W       = 64;
  localparam int HALF_W      = VAL_W / 2;
  localparam int STEP_STAGES = 4;
  localparam int LATENCY     = IDX_BITS * STEP_STAGES;

  typedef struct packed {
    logic                vld;
    logic [IDX_BITS-1:0] idx;
    logic [VAL_W-1:0]    a;
    logic [VAL_W-1:0]    b;
  } tok_t;

endpackage

// ===== hw/rtl/fibfd_step.sv =====
// One fast-doubling step, four register stages.
// Consumes the index MSB and passes the index on shifted left. Uses fibfd_pkg.
module fibfd_step (
  input  logic             clk,
  input  logic             rst,
  input  fibfd_pkg::tok_t  tok_in,
  output fibfd_pkg::tok_t  tok_out
);

  localparam int HW = fibfd_pkg::HALF_W;
  localparam int VW = fibfd_pkg::VAL_W;
  localparam int IB = fibfd_pkg::IDX_BITS;

  // stage 1: t = 2b - a
  logic          v1;
  logic [IB-1:0] idx1;
  logic [VW-1:0] a1, b1, t1;

  // stage 2: 32x32 partial products
  logic          v2;
  logic [IB-1:0] idx2;
  logic [VW-1:0] at_ll, aa_ll, bb_ll;
  logic [HW-1:0] at_x1, at_x2, aa_x, bb_x;

  // stage 3: c = a*t, d = a*a + b*b
  logic          v3;
  logic [IB-1:0] idx3;
  logic [VW-1:0] c3, d3;

  // stage 4: select on index bit
  logic          v4;
  logic [IB-1:0] idx4;
  logic [VW-1:0] a4, b4;

  logic [HW-1:0] d_x;
  assign d_x = aa_x + bb_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= tok_in.vld;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= tok_in.idx;
    a1   <= tok_in.a;
    b1   <= tok_in.b;
    t1   <= {tok_in.b[VW-2:0], 1'b0} - tok_in.a;

    idx2  <= idx1;
    at_ll <= {{HW{1'b0}}, a1[HW-1:0]} * {{HW{1'b0}}, t1[HW-1:0]};
    at_x1 <= a1[HW-1:0] * t1[VW-1:HW];
    at_x2 <= a1[VW-1:HW] * t1[HW-1:0];
    aa_ll <= {{HW{1'b0}}, a1[HW-1:0]} * {{HW{1'b0}}, a1[HW-1:0]};
    aa_x  <= a1[HW-1:0] * a1[VW-1:HW];
    bb_ll <= {{HW{1'b0}}, b1[HW-1:0]} * {{HW{1'b0}}, b1[HW-1:0]};
    bb_x  <= b1[HW-1:0] * b1[VW-1:HW];

    idx3 <= idx2;
    c3   <= at_ll + {at_x1 + at_x2, {HW{1'b0}}};
    d3   <= aa_ll + bb_ll + {d_x[HW-2:0], 1'b0, {HW{1'b0}}};

    idx4 <= {idx3[IB-2:0], 1'b0};
    if (idx3[IB-1]) begin
      a4 <= d3;
      b4 <= c3 + d3;
    end else begin
      a4 <= c3;
      b4 <= d3;
    end
  end

  assign tok_out.vld = v4;
  assign tok_out.idx = idx4;
  assign tok_out.a   = a4;
  assign tok_out.b   = b4;

endmodule

// ===== hw/rtl/fibonacci_fast_doubling.sv =====
// Top level: F(index) mod 2^64 by fast doubling, one step per index bit.
// Chains fibfd_step instances; uses fibfd_pkg and fibonacci_fast_doubling_defines.svh.
//
//  channel  | handshake      | payload
//  ---------+----------------+-------------------
//  request  | start / busy   | index[15:0]
//  result   | done (strobe)  | fib_value[63:0]
//
// Each index bit costs one doubling step of four stages, so an item passes through the
// whole chain of 16 steps between acceptance and its done strobe.
// A new item may be accepted every cycle; busy is never raised.
// Synchronous reset clears the valid bits of every stage; items in flight are dropped.
// The receiver cannot stall: done is high for exactly one cycle per item.
`include "fibonacci_fast_doubling_defines.svh"

module fibonacci_fast_doubling (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] index,
  output logic        busy,
  output logic        done,
  output logic [63:0] fib_value
);

  fibfd_pkg::tok_t chain [0:fibfd_pkg::IDX_BITS];

  assign busy = 1'b0;

  assign chain[0].vld = start;
  assign chain[0].idx = index[fibfd_pkg::IDX_BITS-1:0];
  assign chain[0].a   = '0;
  assign chain[0].b   = fibfd_pkg::VAL_W'(1);

  for (genvar g = 0; g < fibfd_pkg::IDX_BITS; g++) begin : g_step
    fibfd_step u_step (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[g]),
      .tok_out (chain[g+1])
    );
  end

  assign done      = chain[fibfd_pkg::IDX_BITS].vld;
  assign fib_value = chain[fibfd_pkg::IDX_BITS].a;

  `FIBFD_ASSERT_IMP(a_step_latency, done,
                    $past(chain[fibfd_pkg::IDX_BITS-1].vld, fibfd_pkg::STEP_STAGES))
  `FIBFD_ASSERT_IMP(a_idx_consumed, done, chain[fibfd_pkg::IDX_BITS].idx == '0)
  `FIBFD_ASSERT_DLY(a_zero_index, start && !busy && index == 16'd0, fibfd_pkg::LATENCY,
                    done && fib_value == 64'd0)

endmodule
